/* rtl/core/dfrc_pkg.sv */
// shared types, constants and helpers for the delimited frame receiver
package dfrc_pkg;

    localparam int MAX_BODY_BYTES_DEF = 2048;
    localparam int LEN_W              = 12;
    localparam int BYTE_W             = 8;
    localparam int APB_ADDR_W         = 3;
    localparam int APB_DATA_W         = 32;
    localparam int FIFO_DEPTH         = 4;

    localparam logic [LEN_W-1:0] MAX_FRAME_RESET = 12'd1600;

    localparam logic [BYTE_W-1:0] MARK_BANG = 8'h21;
    localparam logic [BYTE_W-1:0] MARK_AMP  = 8'h26;
    localparam logic [BYTE_W-1:0] MARK_HASH = 8'h23;

    localparam logic [15:0] SUM_ALL_ONES = 16'hFFFF;

    // register index as seen in paddr[2]
    localparam logic REG_MAX_FRAME = 1'b0;

    typedef enum logic [1:0] {
        HUNT,
        SAW_BANG,
        BODY,
        BODY_BANG
    } hunt_mode_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              has_byte;
        logic              frame_end;
        logic [LEN_W-1:0]  frame_length;
        logic              checksum_ok;
        logic              overflow;
        logic              last_of_input;
    } result_t;

    // up to two results produced by one received byte
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

    // 16-bit ones-complement add with end-around carry
    function automatic logic [15:0] add_1c(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] t;
        t = {1'b0, a} + {1'b0, b};
        return t[15:0] + {15'd0, t[16]};
    endfunction

endpackage

/* rtl/core/dfrc_if.sv */
// request channel interfaces for received bytes and results
interface dfrc_in_if
    import dfrc_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface dfrc_out_if
    import dfrc_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              has_byte;
    logic              frame_end;
    logic [LEN_W-1:0]  frame_length;
    logic              checksum_ok;
    logic              overflow;
    logic              last_of_input;

    modport source (output valid, output data_byte, output has_byte, output frame_end,
                    output frame_length, output checksum_ok, output overflow,
                    output last_of_input, input ready);
    modport sink   (input valid, input data_byte, input has_byte, input frame_end,
                    input frame_length, input checksum_ok, input overflow,
                    input last_of_input, output ready);
endinterface

/* rtl/core/dfrc_deframer.sv */
// framing state machine, body count and ones-complement sum
module dfrc_deframer
    import dfrc_pkg::*;
#(
    parameter int MAX_BODY_BYTES = MAX_BODY_BYTES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [BYTE_W-1:0] rx_byte,
    input  logic [LEN_W-1:0]  max_frame,
    output push_t             push
);

    localparam int LEN_MAX = (1 << LEN_W) - 1;
    localparam logic [LEN_W-1:0] LimitCap =
        LEN_W'((MAX_BODY_BYTES > LEN_MAX) ? LEN_MAX : MAX_BODY_BYTES);

    hunt_mode_t        mode_reg, mode_next;
    logic [15:0]       sum_reg, sum_next;
    logic [BYTE_W-1:0] held_reg, held_next;
    logic              odd_reg, odd_next;
    logic [LEN_W-1:0]  count_reg, count_next;
    logic              ovf_reg, ovf_next;

    logic [LEN_W-1:0]  limit;
    logic              room0, room1;
    logic [15:0]       sum1, sum_end;
    logic [BYTE_W-1:0] held1;
    logic              odd1;

    function automatic result_t body_result(input logic [BYTE_W-1:0] b, input logic last);
        result_t r;
        r               = '0;
        r.data_byte     = b;
        r.has_byte      = 1'b1;
        r.last_of_input = last;
        return r;
    endfunction

    assign limit = (max_frame > LimitCap) ? LimitCap : max_frame;
    assign room0 = count_reg < limit;
    assign room1 = ({1'b0, count_reg} + 13'd1) < {1'b0, limit};

    // tail byte padded with a zero high half
    assign sum_end = odd_reg ? add_1c(sum_reg, {8'd0, held_reg}) : sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= HUNT;
            sum_reg   <= '0;
            held_reg  <= '0;
            odd_reg   <= 1'b0;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            mode_reg  <= mode_next;
            sum_reg   <= sum_next;
            held_reg  <= held_next;
            odd_reg   <= odd_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

    always_comb
    begin
        mode_next  = mode_reg;
        sum_next   = sum_reg;
        held_next  = held_reg;
        odd_next   = odd_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        push       = '0;
        sum1       = sum_reg;
        held1      = held_reg;
        odd1       = odd_reg;

        if (accept)
        begin
            unique case (mode_reg)
                HUNT:
                begin
                    if (rx_byte == MARK_BANG)
                        mode_next = SAW_BANG;
                end
                SAW_BANG:
                begin
                    if (rx_byte == MARK_AMP)
                    begin
                        mode_next  = BODY;
                        sum_next   = '0;
                        held_next  = '0;
                        odd_next   = 1'b0;
                        count_next = '0;
                        ovf_next   = 1'b0;
                    end
                    else
                    begin
                        mode_next = HUNT;
                    end
                end
                BODY:
                begin
                    if (rx_byte == MARK_BANG)
                    begin
                        mode_next = BODY_BANG;
                    end
                    else if (room0)
                    begin
                        count_next = count_reg + 12'd1;
                        if (odd_reg)
                        begin
                            sum_next  = add_1c(sum_reg, {rx_byte, held_reg});
                            held_next = '0;
                            odd_next  = 1'b0;
                        end
                        else
                        begin
                            held_next = rx_byte;
                            odd_next  = 1'b1;
                        end
                        push.count = 2'd1;
                        push.first = body_result(rx_byte, 1'b1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
                BODY_BANG:
                begin
                    if (rx_byte == MARK_HASH)
                    begin
                        mode_next                = HUNT;
                        push.count               = 2'd1;
                        push.first.frame_end     = 1'b1;
                        push.first.frame_length  = count_reg;
                        push.first.checksum_ok   = (sum_end == SUM_ALL_ONES);
                        push.first.overflow      = ovf_reg;
                        push.first.last_of_input = 1'b1;
                    end
                    else
                    begin
                        mode_next = BODY;
                        // held '!' goes in first, then the current byte
                        if (room0)
                        begin
                            if (odd_reg)
                            begin
                                sum1  = add_1c(sum_reg, {MARK_BANG, held_reg});
                                held1 = '0;
                                odd1  = 1'b0;
                            end
                            else
                            begin
                                held1 = MARK_BANG;
                                odd1  = 1'b1;
                            end
                            push.first = body_result(MARK_BANG, !room1);
                            if (room1)
                            begin
                                count_next = count_reg + 12'd2;
                                if (odd1)
                                begin
                                    sum_next  = add_1c(sum1, {rx_byte, held1});
                                    held_next = '0;
                                    odd_next  = 1'b0;
                                end
                                else
                                begin
                                    sum_next  = sum1;
                                    held_next = rx_byte;
                                    odd_next  = 1'b1;
                                end
                                push.count  = 2'd2;
                                push.second = body_result(rx_byte, 1'b1);
                            end
                            else
                            begin
                                count_next = count_reg + 12'd1;
                                sum_next   = sum1;
                                held_next  = held1;
                                odd_next   = odd1;
                                ovf_next   = 1'b1;
                                push.count = 2'd1;
                            end
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                    end
                end
                default:
                begin
                    mode_next = HUNT;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_pair_only_after_bang: assert property (@(posedge clk) disable iff (!rst_n)
        (push.count == 2'd2) |-> (mode_reg == BODY_BANG))
        else $error("two results outside a released marker");

    a_held_clear_when_even: assert property (@(posedge clk) disable iff (!rst_n)
        !odd_reg |-> (held_reg == '0))
        else $error("held byte not cleared on even position");

    a_end_returns_to_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        (push.count != 2'd0 && push.first.frame_end) |=> (mode_reg == HUNT))
        else $error("frame end did not return to hunt");
`endif

endmodule

/* rtl/core/dfrc_result_fifo.sv */
// small result queue between the deframer and the output channel
module dfrc_result_fifo
    import dfrc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  push_t      push,
    output logic       space,
    dfrc_out_if.source out_ch
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = PTR_W + 1;

    result_t            mem [FIFO_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               pop;
    result_t            head;

    assign space = cnt_reg <= CNT_W'(FIFO_DEPTH - 2);
    assign pop   = out_ch.valid && out_ch.ready;
    assign head  = mem[rd_ptr_reg];

    assign out_ch.valid         = cnt_reg != '0;
    assign out_ch.data_byte     = head.data_byte;
    assign out_ch.has_byte      = head.has_byte;
    assign out_ch.frame_end     = head.frame_end;
    assign out_ch.frame_length  = head.frame_length;
    assign out_ch.checksum_ok   = head.checksum_ok;
    assign out_ch.overflow      = head.overflow;
    assign out_ch.last_of_input = head.last_of_input;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.count);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        cnt_next    = cnt_reg + CNT_W'(push.count) - CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            mem[wr_ptr_reg] <= push.first;
        if (push.count == 2'd2)
            mem[PTR_W'(wr_ptr_reg + 1'b1)] <= push.second;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

`ifndef SYNTHESIS
    a_cnt_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(FIFO_DEPTH))
        else $error("result queue count out of range");

    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push.count != 2'd0) |-> space)
        else $error("push into result queue without room");

    a_ptrs_track_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        PTR_W'(wr_ptr_reg - rd_ptr_reg) == cnt_reg[PTR_W-1:0])
        else $error("queue pointers disagree with count");
`endif

endmodule

/* rtl/core/delimited_frame_receiver_checksum.sv */
// top level of the delimited frame receiver with ones-complement body check
//
// usage
//   in_ch carries one received byte per request; out_ch carries result requests
//   (body bytes released, or one frame-end summary with length, checksum flag
//   and overflow). a byte may cause zero, one or two results; last_of_input
//   marks the final result of a byte. max_frame_bytes sits at apb address 0.
// queueing and throughput
//   a result enters the result queue at the edge that accepts its byte.
//   one byte is taken per cycle while the queue has room; a released '!' plus
//   its follower makes two results, and out_ch drains one per cycle while
//   out_ch.ready is high. the rate is set by the four-entry result queue:
//   in_ch.ready is high while the queue has room for two results.
// reset
//   rst_n clears the hunt state, sum, count and queue; max_frame_bytes
//   returns to 1600.
// stalls
//   when out_ch.ready is low the queue fills and in_ch.ready drops; no byte
//   or result is lost.
module delimited_frame_receiver_checksum
    import dfrc_pkg::*;
#(
    parameter int MAX_BODY_BYTES = MAX_BODY_BYTES_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    dfrc_in_if.sink               in_ch,
    dfrc_out_if.source            out_ch,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [LEN_W-1:0] max_frame_reg;
    logic             cfg_write;
    logic             space;
    logic             accept;
    push_t            push;

    // apb: single register, no wait states
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_MAX_FRAME);
    assign prdata    = (paddr[2] == REG_MAX_FRAME) ? APB_DATA_W'(max_frame_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_frame_reg <= MAX_FRAME_RESET;
        else if (cfg_write)
            max_frame_reg <= pwdata[LEN_W-1:0];
    end

    // byte request taken whenever the queue can absorb two results
    assign in_ch.ready = space;
    assign accept      = in_ch.valid && space;

    // framing, count and sum; results land in the queue at the accept edge
    dfrc_deframer #(
        .MAX_BODY_BYTES (MAX_BODY_BYTES)
    ) u_deframer (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .rx_byte   (in_ch.rx_byte),
        .max_frame (max_frame_reg),
        .push      (push)
    );

    // output queue decouples the link side from a stalling consumer
    dfrc_result_fifo u_result_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .space  (space),
        .out_ch (out_ch)
    );

endmodule

/* tb/deframer_check_pkg.sv */
// predictor and result checker for the delimited frame receiver testbench
`timescale 1ns / 1ps

package deframer_check_pkg;
    import dfrc_pkg::*;

    class deframer_check;
        logic [LEN_W-1:0] limit_reg;
        hunt_mode_t       mode;
        logic [15:0]      word_sum;
        logic [7:0]       low_byte;
        bit               low_pending;
        int unsigned      kept_count;
        bit               dropped;
        result_t          expected_results[$];
        int unsigned      mismatches;

        function new();
            limit_reg   = MAX_FRAME_RESET;
            mode        = HUNT;
            word_sum    = '0;
            low_byte    = '0;
            low_pending = 1'b0;
            kept_count  = 0;
            dropped     = 1'b0;
            mismatches  = 0;
        endfunction

        function void write_register(int unsigned index, logic [APB_DATA_W-1:0] value);
            if (index == int'(REG_MAX_FRAME))
                limit_reg = value[LEN_W-1:0];
        endfunction

        function int unsigned pending();
            return expected_results.size();
        endfunction

        // ones-complement add with end-around carry
        function logic [15:0] ones_add(logic [15:0] a, logic [15:0] b);
            logic [16:0] t;
            t = {1'b0, a} + {1'b0, b};
            return t[15:0] + {15'd0, t[16]};
        endfunction

        // keeps a body byte if the length limit allows it
        function bit keep_byte(logic [7:0] b);
            int unsigned cap;
            cap = (limit_reg > MAX_BODY_BYTES_DEF) ? MAX_BODY_BYTES_DEF : limit_reg;
            if (kept_count >= cap)
            begin
                dropped = 1'b1;
                return 1'b0;
            end
            kept_count++;
            if (low_pending)
            begin
                word_sum    = ones_add(word_sum, {b, low_byte});
                low_pending = 1'b0;
                low_byte    = '0;
            end
            else
            begin
                low_byte    = b;
                low_pending = 1'b1;
            end
            return 1'b1;
        endfunction

        function result_t data_result(logic [7:0] b);
            result_t r;
            r           = '0;
            r.data_byte = b;
            r.has_byte  = 1'b1;
            return r;
        endfunction

        function void take_byte(logic [7:0] b);
            result_t     made [2];
            int          n;
            logic [15:0] s;
            n = 0;
            case (mode)
                HUNT:
                begin
                    if (b == MARK_BANG)
                        mode = SAW_BANG;
                end
                SAW_BANG:
                begin
                    if (b == MARK_AMP)
                    begin
                        mode        = BODY;
                        word_sum    = '0;
                        low_byte    = '0;
                        low_pending = 1'b0;
                        kept_count  = 0;
                        dropped     = 1'b0;
                    end
                    else
                    begin
                        mode = HUNT;
                    end
                end
                BODY:
                begin
                    if (b == MARK_BANG)
                        mode = BODY_BANG;
                    else if (keep_byte(b))
                    begin
                        made[n] = data_result(b);
                        n++;
                    end
                end
                default:
                begin
                    if (b == MARK_HASH)
                    begin
                        s = word_sum;
                        if (low_pending)
                            s = ones_add(s, {8'h00, low_byte});
                        made[n]              = '0;
                        made[n].frame_end    = 1'b1;
                        made[n].frame_length = LEN_W'(kept_count);
                        made[n].checksum_ok  = (s == SUM_ALL_ONES);
                        made[n].overflow     = dropped;
                        n++;
                        mode = HUNT;
                    end
                    else
                    begin
                        if (keep_byte(MARK_BANG))
                        begin
                            made[n] = data_result(MARK_BANG);
                            n++;
                        end
                        if (keep_byte(b))
                        begin
                            made[n] = data_result(b);
                            n++;
                        end
                        mode = BODY;
                    end
                end
            endcase
            for (int i = 0; i < n; i++)
            begin
                if (i == n - 1)
                    made[i].last_of_input = 1'b1;
                expected_results.push_back(made[i]);
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            bit      bad;
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected: data=%h has=%b end=%b len=%0d ok=%b ovf=%b last=%b",
                             got.data_byte, got.has_byte, got.frame_end, got.frame_length,
                             got.checksum_ok, got.overflow, got.last_of_input);
                return;
            end
            want = expected_results.pop_front();
            bad  = (got.data_byte !== want.data_byte) || (got.has_byte !== want.has_byte) ||
                   (got.frame_end !== want.frame_end) ||
                   (got.frame_length !== want.frame_length) ||
                   (got.checksum_ok !== want.checksum_ok) || (got.overflow !== want.overflow) ||
                   (got.last_of_input !== want.last_of_input);
            if (bad)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("result mismatch at %0t", $realtime);
                    $display("  expected: data=%h has=%b end=%b len=%0d ok=%b ovf=%b last=%b",
                             want.data_byte, want.has_byte, want.frame_end, want.frame_length,
                             want.checksum_ok, want.overflow, want.last_of_input);
                    $display("  actual:   data=%h has=%b end=%b len=%0d ok=%b ovf=%b last=%b",
                             got.data_byte, got.has_byte, got.frame_end, got.frame_length,
                             got.checksum_ok, got.overflow, got.last_of_input);
                end
            end
        endfunction
    endclass

endpackage

/* tb/testbench.sv */
// top-level testbench for the delimited frame receiver with body checksum
`timescale 1ns / 1ps

module testbench;
    import dfrc_pkg::*;
    import deframer_check_pkg::*;

    // run guard, far above the slowest legal run
    localparam int unsigned CYCLE_LIMIT = 1_000_000;

    // register addresses: the limit register and one unused slot
    localparam logic [APB_ADDR_W-1:0] ADDR_MAX_FRAME = {REG_MAX_FRAME, 2'b00};
    localparam logic [APB_ADDR_W-1:0] ADDR_SPARE     = 3'd4;

    // body fill styles for generated frames
    typedef enum int {
        FILL_MIXED,     // random bytes biased toward the marker codes
        FILL_PLAIN,     // random bytes with no '!' in them
        FILL_SUMMED     // plain bytes plus a closing word that makes the sum all ones
    } fill_t;

    // opening directed sequence
    localparam logic [7:0] OPENING_BYTES [31] = '{
        // '!' followed by an ordinary byte falls back to the hunt
        MARK_BANG, 8'h41,
        // '!' '!' falls back to the hunt as well
        MARK_BANG, MARK_BANG,
        // frame with extreme bytes, a released '!' pair, a double '!' and the end
        MARK_BANG, MARK_AMP, 8'h00, 8'hFF, MARK_BANG, 8'h55,
        MARK_BANG, MARK_BANG, MARK_BANG, MARK_HASH,
        // header-only frame
        MARK_BANG, MARK_AMP, MARK_BANG, MARK_HASH,
        // even body whose sum is all ones
        MARK_BANG, MARK_AMP, 8'hFF, 8'hFF, MARK_BANG, MARK_HASH,
        // odd body with a padded tail, sum all ones
        MARK_BANG, MARK_AMP, 8'h00, 8'hFF, 8'hFF, MARK_BANG, MARK_HASH
    };

    logic clk;
    logic rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    dfrc_in_if  in_ch ();
    dfrc_out_if out_ch ();

    deframer_check deframer;
    int unsigned   reg_errors;
    int unsigned   cycles;
    bit            calm_in;     // no gaps between input requests
    bit            calm_out;    // no stalls on the result side

    delimited_frame_receiver_checksum #(
        .MAX_BODY_BYTES (MAX_BODY_BYTES_DEF)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("delimited_frame_receiver_checksum test failed");
            $finish;
        end
    end

    // gap or stall length: mostly short, now and then long
    function automatic int unsigned gap_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 2);
        else if (r < 93)
            return $urandom_range(3, 6);
        else
            return $urandom_range(7, 30);
    endfunction

    // body byte with the marker codes favored
    function automatic logic [7:0] marker_heavy_byte();
        int unsigned r;
        r = $urandom_range(0, 15);
        if (r < 2)
            return MARK_BANG;
        else if (r == 2)
            return MARK_HASH;
        else if (r == 3)
            return MARK_AMP;
        else
            return 8'($urandom_range(0, 255));
    endfunction

    // body length: mostly short, sometimes at or just past a small limit
    function automatic int unsigned pick_body_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(0, 12);
        else if (r < 90)
            return $urandom_range(13, 40);
        else if (deframer.limit_reg <= 40)
            return deframer.limit_reg + $urandom_range(0, 3);
        else
            return $urandom_range(0, 12);
    endfunction

    // one input request; valid stays high into the next request when there is no gap
    task automatic send_byte(logic [7:0] b);
        int unsigned gap;
        gap = (calm_in || $urandom_range(0, 99) < 60) ? 0 : gap_length();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.rx_byte <= b;
        do
            @(posedge clk);
        while (!in_ch.ready);
        deframer.take_byte(b);
    endtask

    // start marker, body, end marker
    task automatic send_frame(int unsigned len, fill_t fill);
        logic [15:0] acc;
        logic [7:0]  lo;
        logic [7:0]  b;
        int unsigned body_len;
        acc      = '0;
        lo       = '0;
        body_len = (fill == FILL_SUMMED) ? (len & ~32'd1) : len;
        send_byte(MARK_BANG);
        send_byte(MARK_AMP);
        for (int unsigned i = 0; i < body_len; i++)
        begin
            if (fill == FILL_MIXED)
                b = marker_heavy_byte();
            else
            begin
                b = 8'($urandom_range(0, 255));
                if (b == MARK_BANG)
                    b = b ^ 8'h01;
            end
            // pair up bytes, first one low, to build the closing word
            if (i % 2 == 1)
                acc = deframer.ones_add(acc, {b, lo});
            else
                lo = b;
            send_byte(b);
        end
        if (fill == FILL_SUMMED)
        begin
            send_byte(~acc[7:0]);
            send_byte(~acc[15:8]);
        end
        send_byte(MARK_BANG);
        send_byte(MARK_HASH);
    endtask

    // mostly well-formed frames, the rest broken starts and marker-rich noise
    task automatic run_random(int unsigned target);
        int unsigned done;
        int unsigned r;
        int unsigned len;
        logic [7:0]  b;
        done = 0;
        while (done < target)
        begin
            calm_in = ($urandom_range(0, 4) == 0);
            r       = $urandom_range(0, 99);
            if (r < 72)
            begin
                len = pick_body_length();
                send_frame(len, (r < 18) ? FILL_SUMMED : (r < 24) ? FILL_PLAIN : FILL_MIXED);
                done += len + 4;
            end
            else if (r < 84)
            begin
                // broken start, sometimes with a second '!'
                b = 8'($urandom_range(0, 255));
                if (b == MARK_AMP)
                    b = MARK_BANG;
                send_byte(MARK_BANG);
                send_byte(b);
                done += 2;
            end
            else
            begin
                len = $urandom_range(1, 6);
                repeat (len) send_byte(marker_heavy_byte());
                done += len;
            end
        end
        in_ch.valid <= 1'b0;
    endtask

    // wait until every expected result is in and the block has gone quiet
    task automatic settle(int unsigned tail);
        while (deframer.pending() != 0)
            @(posedge clk);
        repeat (tail) @(posedge clk);
    endtask

    task automatic read_reg(logic [APB_ADDR_W-1:0] addr, output logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        data    = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // register write with setup and access cycles, read back where a register lives
    task automatic write_reg(logic [APB_ADDR_W-1:0] addr, logic [APB_DATA_W-1:0] value);
        logic [APB_DATA_W-1:0] back;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        deframer.write_register(int'(addr >> 2), value);
        if (addr == ADDR_MAX_FRAME)
        begin
            @(posedge clk);
            read_reg(addr, back);
            if (back[LEN_W-1:0] !== value[LEN_W-1:0])
            begin
                reg_errors++;
                $display("limit read back %0d, wrote %0d", back[LEN_W-1:0], value[LEN_W-1:0]);
            end
        end
    endtask

    // new limit with random upper bits in the write data
    task automatic set_limit(logic [LEN_W-1:0] limit);
        write_reg(ADDR_MAX_FRAME, ($urandom() & 32'hFFFF_F000) | APB_DATA_W'(limit));
    endtask

    // result side: check accepted results, stall ready at random
    initial
    begin : result_sink
        int unsigned hold_left;
        result_t     got;
        hold_left    = 0;
        calm_out     = 1'b0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
            begin
                got = '{data_byte:     out_ch.data_byte,
                        has_byte:      out_ch.has_byte,
                        frame_end:     out_ch.frame_end,
                        frame_length:  out_ch.frame_length,
                        checksum_ok:   out_ch.checksum_ok,
                        overflow:      out_ch.overflow,
                        last_of_input: out_ch.last_of_input};
                deframer.check_result(got);
            end
            if (hold_left > 0)
            begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                // switch between stretches with and without stalls
                if ($urandom_range(0, 255) == 0)
                    calm_out = ~calm_out;
                if (!calm_out && $urandom_range(0, 5) == 0)
                    hold_left = gap_length();
            end
        end
    end

    initial
    begin : stimulus
        logic [APB_DATA_W-1:0] reset_value;
        deframer      = new();
        reg_errors    = 0;
        calm_in       = 1'b0;
        rst_n         = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.rx_byte = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // limit comes out of reset at its default
        read_reg(ADDR_MAX_FRAME, reset_value);
        if (reset_value[LEN_W-1:0] !== MAX_FRAME_RESET)
        begin
            reg_errors++;
            $display("limit after reset %0d", reset_value[LEN_W-1:0]);
        end

        // directed part at the default limit
        calm_in = 1'b1;
        foreach (OPENING_BYTES[i])
            send_byte(OPENING_BYTES[i]);
        run_random(120);
        settle(4);

        // zero limit: every body byte dropped; the spare slot must leave it alone
        set_limit(12'd0);
        @(posedge clk);
        write_reg(ADDR_SPARE, $urandom());
        run_random(30);
        settle(4);

        // one-byte limit
        set_limit(12'd1);
        run_random(40);
        settle(4);

        // small random limit, overflow reached often
        set_limit(LEN_W'($urandom_range(2, 40)));
        run_random(60);
        settle(4);

        // top register value, clamped to the body size
        set_limit(12'hFFF);
        run_random(30);
        settle(4);

        // limit equal to the body size
        set_limit(LEN_W'(MAX_BODY_BYTES_DEF));
        run_random(60);
        settle(4);

        // back to the default limit
        set_limit(MAX_FRAME_RESET);
        run_random(60);
        settle(8);

        if (deframer.mismatches == 0 && reg_errors == 0 && deframer.pending() == 0)
            $display("delimited_frame_receiver_checksum test passed");
        else
            $display("delimited_frame_receiver_checksum test failed");
        $finish;
    end

endmodule
